// ===== rtl/core/jbt_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jbt_pkg
// Types and constants shared by the JSON byte tokeniser.
// ----------------------------------------------------------------------------
package jbt_pkg;

  localparam int LENGTH_BITS   = 16;
  localparam int POSITION_BITS = 20;

  typedef logic [LENGTH_BITS-1:0]   len_t;
  typedef logic [POSITION_BITS-1:0] pos_t;

  typedef enum logic [3:0] {
    KIND_LBRACE = 4'd0,
    KIND_RBRACE = 4'd1,
    KIND_LBRACK = 4'd2,
    KIND_RBRACK = 4'd3,
    KIND_COLON  = 4'd4,
    KIND_COMMA  = 4'd5,
    KIND_STRING = 4'd6,
    KIND_INT    = 4'd7,
    KIND_FLOAT  = 4'd8,
    KIND_NULL   = 4'd9,
    KIND_TRUE   = 4'd10,
    KIND_FALSE  = 4'd11,
    KIND_END    = 4'd12,
    KIND_ERROR  = 4'd13
  } kind_t;

  typedef enum logic [2:0] {
    ERR_NONE     = 3'd0,
    ERR_ESCAPE   = 3'd1,
    ERR_HEX      = 3'd2,
    ERR_UNTERM   = 3'd3,
    ERR_WORD     = 3'd4,
    ERR_START    = 3'd5
  } err_t;

  typedef enum logic [2:0] {
    M_BETWEEN = 3'd0,
    M_SLASH   = 3'd1,
    M_COMMENT = 3'd2,
    M_STRING  = 3'd3,
    M_ESC     = 3'd4,
    M_HEX     = 3'd5,
    M_WORD    = 3'd6
  } mode_t;

  typedef struct packed {
    kind_t kind;
    err_t  code;
    len_t  len;
    pos_t  line;
    pos_t  col;
  } token_t;

endpackage

// ===== rtl/core/json_byte_tokenizer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// json_byte_tokenizer
// Streaming JSON lexer: one byte per word in, tokens out.
// ----------------------------------------------------------------------------
// Output: tokens are registered; a token appears in the cycle after the byte that completes it is accepted.
// Throughput: one byte per cycle while out_ready keeps the output queue draining;
//   a byte that ends a word may give two tokens, and in_ready stays low until the queue can take two more.
// Reset: rst (synchronous) returns the lexer to between tokens at line 1,
//   column 1 and clears the stop-on-error flag and the output queue.
// ----------------------------------------------------------------------------
module json_byte_tokenizer import jbt_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  data_byte,
  input  logic        doc_end,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [3:0]  token_kind,
  output logic [2:0]  error_code,
  output logic [LENGTH_BITS-1:0]   token_length,
  output logic [POSITION_BITS-1:0] token_line,
  output logic [POSITION_BITS-1:0] token_column,
  output logic        last_of_run
);

  localparam len_t LEN_MAX = '1;
  localparam pos_t POS_MAX = '1;
  localparam pos_t POS_ONE = POSITION_BITS'(1);
  localparam len_t LEN_ONE = LENGTH_BITS'(1);

  // word class flag bits
  localparam int F_BAD = 0, F_DIGIT = 1, F_PERIOD = 2, F_EXP = 3;
  localparam int F_EXP_SIGN = 4, F_EXP_DIGIT = 5;

  // lexer state
  mode_t       mode, mode_next;
  logic [2:0]  hex, hex_next;
  logic [5:0]  flags, flags_next;
  logic [2:0]  kw, kw_next;       // null, true, false still possible
  len_t        len, len_next;
  pos_t        cur_line, cur_line_next, cur_col, cur_col_next;
  pos_t        st_line, st_line_next, st_col, st_col_next;
  logic        stopped, stopped_next;

  // per-byte results
  token_t      tok0, tok1;
  logic [1:0]  n_tok;

  // output queue: two entries, oldest at slot 0, each with last flag
  token_t      q_tok [2];
  logic [1:0]  q_last;
  logic [1:0]  q_cnt;

  logic        acc, pop;
  logic [7:0]  b;
  logic        is_end;

  assign b      = data_byte;
  assign is_end = doc_end || (data_byte == 8'd0);
  // room for two new tokens needed; after any pop the queue must be empty
  assign in_ready  = (q_cnt == 2'd0) || (q_cnt == 2'd1 && out_ready);
  assign acc       = in_valid && in_ready;
  assign out_valid = (q_cnt != 2'd0);
  assign pop       = out_valid && out_ready;

  function automatic logic is_digit(input logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction
  function automatic logic is_hexd(input logic [7:0] c);
    return is_digit(c) || (c >= "a" && c <= "f") || (c >= "A" && c <= "F");
  endfunction
  function automatic logic is_word(input logic [7:0] c);
    return is_digit(c) || (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") ||
           c == "." || c == "-";
  endfunction
  function automatic logic is_space(input logic [7:0] c);
    return c == " " || (c >= 8'd9 && c <= 8'd13);
  endfunction
  function automatic len_t sinc(input len_t v);
    return (v == LEN_MAX) ? v : v + LEN_ONE;
  endfunction
  function automatic pos_t pinc(input pos_t v);
    return (v == POS_MAX) ? v : v + POS_ONE;
  endfunction
  // expected keyword byte at index i; zero where out of range
  function automatic logic [7:0] kw_char(input int k, input len_t i);
    logic [7:0] c;
    c = 8'd0;
    case (k)
      0: case (i) 0: c = "n"; 1: c = "u"; 2: c = "l"; 3: c = "l"; default: c = 8'd0; endcase
      1: case (i) 0: c = "t"; 1: c = "r"; 2: c = "u"; 3: c = "e"; default: c = 8'd0; endcase
      default: case (i)
        0: c = "f"; 1: c = "a"; 2: c = "l"; 3: c = "s"; 4: c = "e"; default: c = 8'd0;
      endcase
    endcase
    return c;
  endfunction

  always_comb begin
    token_t t;
    logic   word_close, do_between, done;
    logic [5:0] f;
    t = '{kind: KIND_END, code: ERR_NONE, len: '0, line: '0, col: '0};
    mode_next = mode; hex_next = hex; flags_next = flags; kw_next = kw;
    len_next = len; cur_line_next = cur_line; cur_col_next = cur_col;
    st_line_next = st_line; st_col_next = st_col; stopped_next = stopped;
    tok0 = t; tok1 = t; n_tok = 2'd0;
    word_close = 1'b0; do_between = 1'b0; done = 1'b0; f = flags;

    if (!stopped) begin
      case (mode)
        M_WORD: begin
          if (!is_end && is_word(b)) begin
            if (!f[F_BAD]) begin
              if (is_digit(b)) begin
                if (f[F_EXP]) f[F_EXP_DIGIT] = 1'b1; else f[F_DIGIT] = 1'b1;
              end else if (b == "-") begin
                if (len == '0) f = f;
                else if (f[F_EXP] && !f[F_EXP_SIGN] && !f[F_EXP_DIGIT]) f[F_EXP_SIGN] = 1'b1;
                else f[F_BAD] = 1'b1;
              end else if (b == ".") begin
                if (f[F_EXP] || f[F_PERIOD]) f[F_BAD] = 1'b1; else f[F_PERIOD] = 1'b1;
              end else if (b == "e") begin
                if (f[F_EXP] || !f[F_DIGIT]) f[F_BAD] = 1'b1; else f[F_EXP] = 1'b1;
              end else begin
                f[F_BAD] = 1'b1;
              end
            end
            flags_next = f;
            for (int k = 0; k < 3; k++)
              if (kw_char(k, len) != b) kw_next[k] = 1'b0;
            len_next = sinc(len);
          end else begin
            word_close = 1'b1;
          end
        end
        M_SLASH: begin
          if (!is_end && b == "/") mode_next = M_COMMENT;
          else begin
            tok0 = '{KIND_ERROR, ERR_START, LEN_ONE, st_line, st_col};
            n_tok = 2'd1; stopped_next = 1'b1; mode_next = M_BETWEEN;
          end
        end
        M_COMMENT: begin
          if (is_end) do_between = 1'b1;
          else if (b == 8'h0a) mode_next = M_BETWEEN;
        end
        M_STRING, M_ESC, M_HEX: begin
          if (is_end) begin
            tok0 = '{KIND_ERROR, (mode == M_STRING) ? ERR_UNTERM :
                     (mode == M_ESC) ? ERR_ESCAPE : ERR_HEX, len, st_line, st_col};
            n_tok = 2'd1; stopped_next = 1'b1; mode_next = M_BETWEEN;
          end else begin
            len_next = sinc(len);
            if (mode == M_STRING) begin
              if (b == "\"") begin
                mode_next = M_BETWEEN;
                tok0 = '{KIND_STRING, ERR_NONE, sinc(len), st_line, st_col};
                n_tok = 2'd1;
              end else if (b == "\\") mode_next = M_ESC;
            end else if (mode == M_ESC) begin
              if (b == "\"" || b == "\\" || b == "/" || b == "b" || b == "f" ||
                  b == "n" || b == "r" || b == "t") mode_next = M_STRING;
              else if (b == "u") begin
                hex_next = 3'd0; mode_next = M_HEX;
              end else begin
                tok0 = '{KIND_ERROR, ERR_ESCAPE, sinc(len), st_line, st_col};
                n_tok = 2'd1; stopped_next = 1'b1; mode_next = M_BETWEEN;
              end
            end else begin
              if (is_hexd(b)) begin
                if (hex == 3'd3) begin
                  hex_next = 3'd0; mode_next = M_STRING;
                end else hex_next = hex + 3'd1;
              end else begin
                tok0 = '{KIND_ERROR, ERR_HEX, sinc(len), st_line, st_col};
                n_tok = 2'd1; stopped_next = 1'b1; mode_next = M_BETWEEN;
              end
            end
          end
        end
        default: do_between = 1'b1;
      endcase

      // word finish: classify; for a valid word the closing byte then starts afresh
      if (word_close) begin
        mode_next = M_BETWEEN;
        n_tok = 2'd1;
        if (!flags[F_BAD] && flags[F_DIGIT] && !flags[F_PERIOD] && !flags[F_EXP]) begin
          tok0 = '{KIND_INT, ERR_NONE, len, st_line, st_col}; do_between = 1'b1;
        end else if (!flags[F_BAD] && flags[F_DIGIT] &&
                     (!flags[F_EXP] || flags[F_EXP_DIGIT])) begin
          tok0 = '{KIND_FLOAT, ERR_NONE, len, st_line, st_col}; do_between = 1'b1;
        end else if (kw[0] && len == LENGTH_BITS'(4)) begin
          tok0 = '{KIND_NULL, ERR_NONE, len, st_line, st_col}; do_between = 1'b1;
        end else if (kw[1] && len == LENGTH_BITS'(4)) begin
          tok0 = '{KIND_TRUE, ERR_NONE, len, st_line, st_col}; do_between = 1'b1;
        end else if (kw[2] && len == LENGTH_BITS'(5)) begin
          tok0 = '{KIND_FALSE, ERR_NONE, len, st_line, st_col}; do_between = 1'b1;
        end else begin
          tok0 = '{KIND_ERROR, ERR_WORD, len, st_line, st_col};
          stopped_next = 1'b1;
        end
      end

      if (do_between) begin
        mode_next = M_BETWEEN;
        t = '{KIND_END, ERR_NONE, LEN_ONE, cur_line, cur_col};
        if (is_end) begin
          done = 1'b1; t.len = '0;
          if (n_tok == 2'd0) begin tok0 = t; n_tok = 2'd1; end
          else begin tok1 = t; n_tok = 2'd2; end
        end else if (!is_space(b)) begin
          logic emit_t;
          emit_t = 1'b1;
          case (b)
            "{": t.kind = KIND_LBRACE;
            "}": t.kind = KIND_RBRACE;
            "[": t.kind = KIND_LBRACK;
            "]": t.kind = KIND_RBRACK;
            ":": t.kind = KIND_COLON;
            ",": t.kind = KIND_COMMA;
            "/", "\"": begin
              emit_t = 1'b0;
              mode_next = (b == "/") ? M_SLASH : M_STRING;
              st_line_next = cur_line; st_col_next = cur_col; len_next = LEN_ONE;
            end
            default: begin
              st_line_next = cur_line; st_col_next = cur_col;
              mode_next = M_WORD;
              if (is_word(b)) begin
                emit_t = 1'b0;
                f = '0;
                if (is_digit(b)) f[F_DIGIT] = 1'b1;
                else if (b == "." ) f[F_PERIOD] = 1'b1;
                else if (b != "-") f[F_BAD] = 1'b1;
                flags_next = f;
                for (int k = 0; k < 3; k++) kw_next[k] = (kw_char(k, '0) == b);
                len_next = LEN_ONE;
              end else begin
                t = '{KIND_ERROR, ERR_START, LEN_ONE, cur_line, cur_col};
                stopped_next = 1'b1; mode_next = M_BETWEEN; len_next = LEN_ONE;
              end
            end
          endcase
          if (emit_t) begin
            if (n_tok == 2'd0) begin tok0 = t; n_tok = 2'd1; end
            else begin tok1 = t; n_tok = 2'd2; end
          end
        end
      end

      if (done) begin
        mode_next = M_BETWEEN; hex_next = '0; flags_next = '0; kw_next = '0;
        len_next = '0; cur_line_next = POS_ONE; cur_col_next = POS_ONE;
        st_line_next = POS_ONE; st_col_next = POS_ONE;
      end else if (!is_end && !stopped_next) begin
        if (b == 8'h0a) begin
          cur_line_next = pinc(cur_line); cur_col_next = POS_ONE;
        end else cur_col_next = pinc(cur_col);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= M_BETWEEN; hex <= '0; flags <= '0; kw <= '0; len <= '0;
      cur_line <= POS_ONE; cur_col <= POS_ONE; st_line <= POS_ONE; st_col <= POS_ONE;
      stopped <= 1'b0;
    end else if (acc) begin
      mode <= mode_next; hex <= hex_next; flags <= flags_next; kw <= kw_next;
      len <= len_next; cur_line <= cur_line_next; cur_col <= cur_col_next;
      st_line <= st_line_next; st_col <= st_col_next; stopped <= stopped_next;
    end
  end

  // output queue; an accepted byte always finds it empty once any pop is
  // taken, so new tokens load both slots
  always_ff @(posedge clk) begin
    if (acc && n_tok != 2'd0) begin
      q_tok[0] <= tok0; q_last[0] <= (n_tok == 2'd1);
      q_tok[1] <= tok1; q_last[1] <= 1'b1;
    end else if (pop) begin
      q_tok[0] <= q_tok[1]; q_last[0] <= q_last[1];
    end
    if (rst) q_cnt <= 2'd0;
    else     q_cnt <= q_cnt - {1'b0, pop} + (acc ? n_tok : 2'd0);
  end

  assign token_kind   = q_tok[0].kind;
  assign error_code   = q_tok[0].code;
  assign token_length = q_tok[0].len;
  assign token_line   = q_tok[0].line;
  assign token_column = q_tok[0].col;
  assign last_of_run  = q_last[0];

endmodule
